[hdl/uhcb_pkg.sv]
// Shared types, constants and checksum helpers for the UDP header checksum builder.
// No dependencies; used by every module of the block.
`default_nettype none

package uhcb_pkg;

    localparam int MaxPayload = 65527;
    localparam int PaddrW     = 3;

    localparam logic [15:0] UdpHdrBytes = 16'd8;
    localparam logic [15:0] ProtoUdp    = 16'd17;
    localparam logic [15:0] AllOnes     = 16'hFFFF;

    // register index is paddr[2]
    localparam logic RegSrcAddr = 1'b0;
    localparam logic RegDstAddr = 1'b1;

    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] sum;
        logic [15:0] len;
        logic        ovf;
    } t_fin;

    // 16-bit end-around-carry add
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    // fold a sum of up to eight 16-bit terms back into 16 bits
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] f;
        f = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        return f[15:0] + {15'b0, f[16]};
    endfunction

endpackage

`default_nettype wire

[hdl/udp_header_checksum_builder_top.sv]
// UDP header and checksum builder: one payload byte per request in, one
// header result per packet out. Depends on uhcb_pkg, uhcb_cfg, uhcb_accum, uhcb_final.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one payload byte per request;
//   i_byte_valid = 0 marks a request without a byte (empty payload), i_last_byte
//   ends the packet. Ports are sampled on the first request of a packet.
//   Output channel (o_out_valid / i_out_ready) gives ports, UDP length and the
//   checksum once per packet, or length_overflow when the payload is too long.
//   The APB port holds the IPv4 source (0x0) and destination (0x4) addresses;
//   write them while no packet is in flight.
// Timing:
//   One request per clock cycle while o_in_ready stays high. After the last
//   request of a packet is accepted, its result passes the input register,
//   accumulator and output register. The pseudo-header address sum is refolded
//   every cycle from the address registers.
// Reset and stall:
//   Synchronous active-low reset empties the pipeline and clears both addresses.
//   While the receiver stalls, requests keep flowing until the last request of a
//   packet reaches the input register while a finished packet already waits
//   behind the output register; then o_in_ready drops.
`default_nettype none

module udp_header_checksum_builder_top #(
    parameter int MAX_PAYLOAD = uhcb_pkg::MaxPayload
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uhcb_pkg::PaddrW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_payload_byte,
    input  wire logic                         i_byte_valid,
    input  wire logic                         i_last_byte,
    input  wire logic [15:0]                  i_src_port,
    input  wire logic [15:0]                  i_dst_port,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [15:0]                  o_out_src_port,
    output logic      [15:0]                  o_out_dst_port,
    output logic      [15:0]                  o_udp_length,
    output logic      [15:0]                  o_udp_checksum,
    output logic                              o_length_overflow
);

    logic [15:0]    pseudo_sum;
    uhcb_pkg::t_fin fin;
    logic           fin_valid;
    logic           fin_ready;

    uhcb_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_pseudo_sum (pseudo_sum)
    );

    uhcb_accum #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_byte_valid   (i_byte_valid),
        .i_last_byte    (i_last_byte),
        .i_src_port     (i_src_port),
        .i_dst_port     (i_dst_port),
        .o_fin          (fin),
        .o_fin_valid    (fin_valid),
        .i_fin_ready    (fin_ready)
    );

    uhcb_final u_final (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fin             (fin),
        .i_fin_valid       (fin_valid),
        .o_fin_ready       (fin_ready),
        .i_pseudo_sum      (pseudo_sum),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_src_port    (o_out_src_port),
        .o_out_dst_port    (o_out_dst_port),
        .o_udp_length      (o_udp_length),
        .o_udp_checksum    (o_udp_checksum),
        .o_length_overflow (o_length_overflow)
    );

endmodule

`default_nettype wire

[hdl/uhcb_cfg.sv]
// APB register file: IPv4 source and destination addresses, plus the
// pre-folded pseudo-header sum (addresses and protocol). Depends on uhcb_pkg.
`default_nettype none

module uhcb_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uhcb_pkg::PaddrW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output logic      [15:0]                  o_pseudo_sum
);

    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [15:0] r_pseudo;
    logic [15:0] n_pseudo;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= '0;
            r_dst_addr <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                uhcb_pkg::RegSrcAddr: r_src_addr <= pwdata;
                uhcb_pkg::RegDstAddr: r_dst_addr <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            uhcb_pkg::RegSrcAddr: prdata = r_src_addr;
            uhcb_pkg::RegDstAddr: prdata = r_dst_addr;
            default:              prdata = '0;
        endcase
    end

    assign n_pseudo = uhcb_pkg::oc_fold(19'(r_src_addr[31:16]) + 19'(r_src_addr[15:0])
                                      + 19'(r_dst_addr[31:16]) + 19'(r_dst_addr[15:0])
                                      + 19'(uhcb_pkg::ProtoUdp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pseudo <= uhcb_pkg::ProtoUdp;
        end else begin
            r_pseudo <= n_pseudo;
        end
    end

    assign o_pseudo_sum = r_pseudo;

endmodule

`default_nettype wire

[hdl/uhcb_accum.sv]
// Input register and per-packet accumulator: pairs bytes into a ones-complement
// sum, counts bytes and emits a packet summary on the last request. Uses uhcb_pkg.
`default_nettype none

module uhcb_accum #(
    parameter int MAX_PAYLOAD = uhcb_pkg::MaxPayload
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_payload_byte,
    input  wire logic           i_byte_valid,
    input  wire logic           i_last_byte,
    input  wire logic [15:0]    i_src_port,
    input  wire logic [15:0]    i_dst_port,
    output uhcb_pkg::t_fin      o_fin,
    output logic                o_fin_valid,
    input  wire logic           i_fin_ready
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
    localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_PAYLOAD);

    // input register
    logic             r_in_v;
    logic [7:0]       r_in_byte;
    logic             r_in_bv;
    logic             r_in_last;
    logic [15:0]      r_in_src;
    logic [15:0]      r_in_dst;

    // packet state
    logic             r_pkt;
    logic [15:0]      r_sum;
    logic [7:0]       r_hold;
    logic             r_odd;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_src;
    logic [15:0]      r_dst;

    logic             r_fin_v;
    uhcb_pkg::t_fin   r_fin;

    logic             start;
    logic [15:0]      b_sum;
    logic [7:0]       b_hold;
    logic             b_odd;
    logic [CNT_W-1:0] b_cnt;
    logic             pair;
    logic             pad;
    logic [15:0]      addend;
    logic [15:0]      n_sum;
    logic [7:0]       n_hold;
    logic             n_odd;
    logic [CNT_W-1:0] n_cnt;
    logic [15:0]      n_src;
    logic [15:0]      n_dst;
    logic             n_ovf;
    uhcb_pkg::t_fin   n_fin;
    logic             fin_free;
    logic             take;

    // a request seen outside a packet opens one and starts from clean state
    assign start  = !r_pkt;
    assign b_sum  = start ? '0 : r_sum;
    assign b_hold = start ? '0 : r_hold;
    assign b_odd  = start ? 1'b0 : r_odd;
    assign b_cnt  = start ? '0 : r_cnt;
    assign n_src  = start ? r_in_src : r_src;
    assign n_dst  = start ? r_in_dst : r_dst;

    assign pair   = r_in_bv && b_odd;
    assign n_hold = (r_in_bv && !b_odd) ? r_in_byte : b_hold;
    assign n_odd  = r_in_bv ? !b_odd : b_odd;
    // pad an odd trailing byte; never coincides with a pair completing
    assign pad    = r_in_last && n_odd;
    assign addend = pair ? {b_hold, r_in_byte} : {n_hold, 8'h00};
    assign n_sum  = (pair || pad) ? uhcb_pkg::oc_add(b_sum, addend) : b_sum;
    assign n_cnt  = (r_in_bv && (b_cnt <= CntMax)) ? b_cnt + 1'b1 : b_cnt;
    assign n_ovf  = n_cnt > CntMax;

    always_comb begin
        n_fin.src_port = n_src;
        n_fin.dst_port = n_dst;
        n_fin.ovf      = n_ovf;
        n_fin.sum      = n_ovf ? '0 : n_sum;
        n_fin.len      = n_ovf ? '0 : (16'(n_cnt) + uhcb_pkg::UdpHdrBytes);
    end

    assign fin_free   = !r_fin_v || i_fin_ready;
    assign take       = r_in_v && (!r_in_last || fin_free);
    assign o_in_ready = !r_in_v || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_payload_byte;
            r_in_bv   <= i_byte_valid;
            r_in_last <= i_last_byte;
            r_in_src  <= i_src_port;
            r_in_dst  <= i_dst_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= 1'b0;
            r_odd <= 1'b0;
            r_cnt <= '0;
        end else if (take) begin
            r_pkt <= !r_in_last;
            r_odd <= n_odd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sum  <= n_sum;
            r_hold <= n_hold;
            r_src  <= n_src;
            r_dst  <= n_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (fin_free) begin
            r_fin_v <= take && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_in_last) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin       = r_fin;
    assign o_fin_valid = r_fin_v;

    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntMax + 1'b1)
        else $error("byte count beyond saturation");

    a_close_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_last |=> !r_pkt && r_fin_v)
        else $error("last request did not close the packet");

endmodule

`default_nettype wire

[hdl/uhcb_final.sv]
// Final stage: adds ports, length and pseudo-header to the payload sum,
// complements it and holds the result in the output register. Uses uhcb_pkg.
`default_nettype none

module uhcb_final (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  uhcb_pkg::t_fin      i_fin,
    input  wire logic           i_fin_valid,
    output logic                o_fin_ready,
    input  wire logic [15:0]    i_pseudo_sum,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic      [15:0]    o_out_src_port,
    output logic      [15:0]    o_out_dst_port,
    output logic      [15:0]    o_udp_length,
    output logic      [15:0]    o_udp_checksum,
    output logic                o_length_overflow
);

    logic        r_out_v;
    logic [15:0] r_src;
    logic [15:0] r_dst;
    logic [15:0] r_len;
    logic [15:0] r_csum;
    logic        r_ovf;

    logic [15:0] folded;
    logic [15:0] inv;
    logic [15:0] n_csum;
    logic        out_free;

    // length counts twice: once in the pseudo-header, once in the UDP header
    assign folded = uhcb_pkg::oc_fold(19'(i_fin.sum) + 19'(i_pseudo_sum)
                                    + 19'(i_fin.len) + 19'(i_fin.len)
                                    + 19'(i_fin.src_port) + 19'(i_fin.dst_port));
    assign inv    = ~folded;

    always_comb begin
        if (i_fin.ovf) begin
            n_csum = '0;
        end else if (inv == 16'h0000) begin
            n_csum = uhcb_pkg::AllOnes;
        end else begin
            n_csum = inv;
        end
    end

    assign out_free    = !r_out_v || i_out_ready;
    assign o_fin_ready = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid && out_free) begin
            r_src  <= i_fin.src_port;
            r_dst  <= i_fin.dst_port;
            r_len  <= i_fin.len;
            r_csum <= n_csum;
            r_ovf  <= i_fin.ovf;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_out_src_port    = r_src;
    assign o_out_dst_port    = r_dst;
    assign o_udp_length      = r_len;
    assign o_udp_checksum    = r_csum;
    assign o_length_overflow = r_ovf;

    a_good_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_length_overflow |-> o_udp_checksum != 16'h0000 &&
                                              o_udp_length >= uhcb_pkg::UdpHdrBytes)
        else $error("valid result with zero checksum or short length");

    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_overflow |-> o_udp_checksum == 16'h0000 &&
                                             o_udp_length == 16'h0000)
        else $error("overflow result carries length or checksum");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fin_valid && o_fin_ready |=> o_out_valid)
        else $error("summary taken but no result shown");

endmodule

`default_nettype wire
